// ===== design/mme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  localparam int IDX_W   = 3;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 40;
  localparam int DIM_W   = 4;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [PROD_W-1:0] product_value;
    logic                     shape_error;
    logic                     last_item;
  } out_req_t;

  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic             rd_en;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
    logic             acc_clr;
    logic             out_load;
    logic             shape_error;
    logic             last_item;
  } mme_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mme_stat_t;

endpackage

`default_nettype wire

// ===== design/mme_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/mme_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mme_ctrl #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire mme_pkg::in_req_t                 in_req_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mme_pkg::DIM_W-1:0]        cfg_data_i,
  output mme_pkg::mme_cmd_t                     cmd_o,
  input  wire mme_pkg::mme_stat_t               stat_i
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW = mme_pkg::DIM_W;
  localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIM);
  localparam logic [DW-1:0] DIM_ONE = DW'(1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          err_q, err_d;
  logic [DW-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [DW-1:0] ra, ca, rb, cb;
  logic          in_range, i_last, j_last, k_last, elem_last;

  function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_ONE;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= mme_pkg::DIM_RESET;
      cols_a_q <= mme_pkg::DIM_RESET;
      rows_b_q <= mme_pkg::DIM_RESET;
      cols_b_q <= mme_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mme_pkg::REG_ROWS_A: rows_a_q <= cfg_data_i;
        mme_pkg::REG_COLS_A: cols_a_q <= cfg_data_i;
        mme_pkg::REG_ROWS_B: rows_b_q <= cfg_data_i;
        mme_pkg::REG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ra = eff_dim(rows_a_q);
  assign ca = eff_dim(cols_a_q);
  assign rb = eff_dim(rows_b_q);
  assign cb = eff_dim(cols_b_q);

  assign in_range  = (int'(in_req_i.row_index) < MAX_DIM) &&
                     (int'(in_req_i.col_index) < MAX_DIM);
  assign i_last    = (DW'(i_q) == ra - DIM_ONE);
  assign j_last    = (DW'(j_q) == cb - DIM_ONE);
  assign k_last    = (DW'(k_q) == ca - DIM_ONE);
  assign elem_last = err_q || (i_last && j_last);

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.row         = mme_pkg::IDX_W'(i_q);
    cmd_o.col         = mme_pkg::IDX_W'(j_q);
    cmd_o.k           = mme_pkg::IDX_W'(k_q);
    cmd_o.shape_error = err_q;
    cmd_o.last_item   = elem_last;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_req_i.command)
            mme_pkg::CMD_WRITE_A: cmd_o.we_a = in_range;
            mme_pkg::CMD_WRITE_B: cmd_o.we_b = in_range;
            mme_pkg::CMD_COMPUTE: begin
              cmd_o.acc_clr = 1'b1;
              i_d = '0;
              j_d = '0;
              k_d = '0;
              if (ca != rb) begin
                err_d   = 1'b1;
                state_d = ST_EMIT;
              end else begin
                err_d   = 1'b0;
                state_d = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.rd_en = 1'b1;
        if (k_last) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (elem_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_MAC;
            if (j_last) begin
              j_d = '0;
              i_d = i_q + IW'(1);
            end else begin
              j_d = j_q + IW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mme_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mme_datapath #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mme_pkg::in_req_t   in_req_i,
  input  wire mme_pkg::mme_cmd_t  cmd_i,
  output mme_pkg::mme_stat_t      stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mme_pkg::out_req_t       out_req_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * ELEM_WIDTH;
  localparam int PRW   = mme_pkg::PROD_W;
  localparam int EXT_W = (PW > PRW) ? PW : PRW;

  logic [AW-1:0]                waddr, a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0]        wdata, a_rdata, b_rdata;
  logic                         v1_q, v2_q;
  logic signed [PW-1:0]         prod_q;
  logic signed [EXT_W-1:0]      prod_ext;
  logic signed [PRW-1:0]        acc_q;
  logic                         out_valid_q;
  mme_pkg::out_req_t            out_q;

  assign waddr   = AW'(int'(in_req_i.row_index) * MAX_DIM + int'(in_req_i.col_index));
  assign a_raddr = AW'(int'(cmd_i.row) * MAX_DIM + int'(cmd_i.k));
  assign b_raddr = AW'(int'(cmd_i.k) * MAX_DIM + int'(cmd_i.col));
  assign wdata   = ELEM_WIDTH'($signed(in_req_i.element_value));

  mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= PW'($signed(a_rdata)) * PW'($signed(b_rdata));
    end
  end

  assign prod_ext = EXT_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + prod_ext[PRW-1:0];
    end
  end

  assign stat_o.pipe_busy = v1_q | v2_q;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_row       <= cmd_i.row;
      out_q.out_col       <= cmd_i.col;
      out_q.product_value <= acc_q;
      out_q.shape_error   <= cmd_i.shape_error;
      out_q.last_item     <= cmd_i.last_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire

// ===== design/matrix_multiply_engine.sv =====
// Fixed-point matrix multiply engine, C = A x B, with Q8.8 inputs and Q24.16 results.
// Input channel: in_valid_i, in_stall_o, in_req_i. A write-A or write-B request
// stores one element; a compute request walks the product and emits
// C row by row, left to right, with last_item on the final element.
// If cols_a and rows_b disagree, a compute emits one result with shape_error and
// last_item set and a zero value.
// Output channel: out_valid_o, out_stall_i, out_req_o, from an output register.
// For each element the controller reads a row of A and a column of B from the two
// element stores, lets the read, multiply and accumulate pipeline drain, then loads
// the output register. Configuration is written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must do so only while idle, as the block does not enforce it.
// The input is stalled for the whole compute; write requests are taken every cycle.
// When the receiver stalls, the finished element waits in the output register
// and the walk holds until it is taken.
// Reset clears the control state and sets all four dimension registers to 8.
// The element stores are not cleared and must be written before they are used.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_engine #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire mme_pkg::in_req_t              in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mme_pkg::out_req_t                  out_req_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mme_pkg::DIM_W-1:0]     cfg_data_i
);

  mme_pkg::mme_cmd_t  cmd;
  mme_pkg::mme_stat_t stat;

  mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mme_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("Output register loaded while still holding a stalled request.");

  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !stat.pipe_busy)
    else $error("Result emitted before the accumulate pipeline drained.");

  a_read_or_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !cmd.out_load && !cmd.acc_clr)
    else $error("Store read overlaps an emit or an accumulator clear.");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.shape_error |-> out_req_o.last_item)
    else $error("Shape error result is not marked as the last result.");

endmodule

`default_nettype wire
